FILE: hw/rtl/bal_pkg.sv
//------------------------------------------------------------------------------
// bal_pkg
// Shared constants, opcode codes and status codes for the bounded array list engine.
//------------------------------------------------------------------------------
package bal_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int OP_W     = 4;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = 9;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 4'd0,
		OP_INSERT = 4'd1,
		OP_REMOVE = 4'd2,
		OP_READ   = 4'd3,
		OP_FINDF  = 4'd4,
		OP_FINDL  = 4'd5,
		OP_CLEAR  = 4'd6,
		OP_SORT   = 4'd7,
		OP_MAX    = 4'd8,
		OP_COUNT  = 4'd9
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

endpackage

FILE: hw/rtl/bal_req_if.sv
//------------------------------------------------------------------------------
// bal_req_if
// Request channel: valid/ready with opcode, position and value.
//------------------------------------------------------------------------------
interface bal_req_if;
	logic                      valid;
	logic                      ready;
	logic [bal_pkg::OP_W-1:0]  opcode;
	logic [bal_pkg::POS_W-1:0] position;
	logic signed [bal_pkg::VAL_W-1:0] value;

	modport source (output valid, opcode, position, value, input ready);
	modport sink (input valid, opcode, position, value, output ready);
endinterface

FILE: hw/rtl/bal_rsp_if.sv
//------------------------------------------------------------------------------
// bal_rsp_if
// Result channel: valid/ready with data, position, flag, status and count.
//------------------------------------------------------------------------------
interface bal_rsp_if;
	logic                         valid;
	logic                         ready;
	logic signed [bal_pkg::VAL_W-1:0] data_out;
	logic [bal_pkg::POS_W-1:0]    found_position;
	logic                         found;
	logic [bal_pkg::STATUS_W-1:0] status;
	logic [bal_pkg::CNT_W-1:0]    count;

	modport source (output valid, data_out, found_position, found, status, count,
		input ready);
	modport sink (input valid, data_out, found_position, found, status, count,
		output ready);
endinterface

FILE: hw/rtl/bounded_array_list_engine_top.sv
//------------------------------------------------------------------------------
// bounded_array_list_engine_top
// Ordered list of signed words in a single-port-write, registered-read store,
// walked one entry per step by a small sequencer and one compare unit.
//------------------------------------------------------------------------------
// Flow: append/clear/count/unused go straight to the result; read, find, max and
//   shift: RD, WAIT, EVAL per entry; sort: RD, WAIT, SORTB, SORTW; one read each.
// Throughput: one request at a time; the next is taken once the result is
//   taken. The memory read port and the single compare set the pace.
// Reset: count cleared, sequencer idle; the store has no reset.
//------------------------------------------------------------------------------
module bounded_array_list_engine_top #(
	parameter int CAPACITY   = bal_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	bal_req_if.sink   req,
	bal_rsp_if.source rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_EVAL  = 7'b0001000,
		S_SORTB = 7'b0010000,
		S_SORTW = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q, hold_q, val_q, best_q;
	logic [NW-1:0] cnt_q, idx_q, lim_q;
	logic [bal_pkg::OP_W-1:0] op_q;
	logic [NW-1:0] pos_q;
	logic [AW-1:0] raddr, waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic we, re;
	logic signed [bal_pkg::VAL_W-1:0] dout_q;
	logic [bal_pkg::POS_W-1:0] fpos_q;
	logic found_q;
	logic [bal_pkg::STATUS_W-1:0] st_q;
	logic [DATA_WIDTH-1:0] vin;
	logic [63:0] vext;
	logic gt;

	// value cut to DATA_WIDTH after sign extension
	assign vext = {{32{req.value[31]}}, req.value};
	assign vin  = vext[DATA_WIDTH-1:0];

	// shared signed compare: rdata_q > (hold_q or best_q)
	assign gt = $signed(rdata_q) > $signed((op_q == bal_pkg::OP_MAX) ? best_q : hold_q);

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = (state_q == S_DONE);
	assign rsp.data_out       = dout_q;
	assign rsp.found_position = fpos_q;
	assign rsp.found          = found_q;
	assign rsp.status         = st_q;
	assign rsp.count          = bal_pkg::CNT_W'(cnt_q);

	// store: one write, one registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (req.valid) state_q <= nstate_idle();
				S_RD:   state_q <= S_WAIT;
				S_WAIT: state_q <= (op_q == bal_pkg::OP_SORT) ? S_SORTB : S_EVAL;
				S_EVAL: state_q <= eval_next();
				S_SORTB: state_q <= S_SORTW;
				S_SORTW: state_q <= sortw_next();
				S_DONE: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE && req.valid)
				cnt_q <= cnt_idle();
			if (state_q == S_EVAL && op_q == bal_pkg::OP_REMOVE &&
				!(idx_q + 1'b1 < cnt_q))
				cnt_q <= cnt_q - 1'b1;
			if (state_q == S_EVAL && op_q == bal_pkg::OP_INSERT && idx_q <= pos_q)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	function automatic state_t nstate_idle();
		logic [NW-1:0] p;
		p = NW'(req.position);
		case (req.opcode)
			bal_pkg::OP_INSERT:
				return ((p != '0 && p >= cnt_q) || cnt_q >= NW'(CAPACITY)) ? S_DONE :
					(cnt_q == '0 || cnt_q == p) ? S_EVAL : S_RD;
			bal_pkg::OP_REMOVE, bal_pkg::OP_READ:
				return (p >= cnt_q) ? S_DONE : S_RD;
			bal_pkg::OP_FINDF, bal_pkg::OP_FINDL, bal_pkg::OP_MAX:
				return (cnt_q == '0) ? S_DONE : S_RD;
			bal_pkg::OP_SORT:
				return (cnt_q < NW'(2)) ? S_DONE : S_RD;
			default: return S_DONE;
		endcase
	endfunction

	function automatic logic [NW-1:0] cnt_idle();
		case (req.opcode)
			bal_pkg::OP_APPEND: return (cnt_q >= NW'(CAPACITY)) ? cnt_q : cnt_q + 1'b1;
			bal_pkg::OP_CLEAR:  return '0;
			default:            return cnt_q;
		endcase
	endfunction

	function automatic state_t eval_next();
		case (op_q)
			bal_pkg::OP_INSERT: return (idx_q <= pos_q) ? S_DONE : S_RD;
			bal_pkg::OP_REMOVE: return (idx_q + 1'b1 < cnt_q) ? S_RD : S_DONE;
			bal_pkg::OP_FINDF:
				return (rdata_q == val_q || idx_q + 1'b1 >= cnt_q) ? S_DONE : S_RD;
			bal_pkg::OP_FINDL:
				return (rdata_q == val_q || idx_q == '0) ? S_DONE : S_RD;
			bal_pkg::OP_MAX: return (idx_q + 1'b1 >= cnt_q) ? S_DONE : S_RD;
			default: return S_DONE;
		endcase
	endfunction

	// sort: idx_q = j+1 being compared against hold_q = running element at j
	function automatic state_t sortw_next();
		if (idx_q + 1'b1 < lim_q)
			return S_RD;
		if (lim_q > NW'(2))
			return S_RD;
		return S_DONE;
	endfunction

	// read address and store write control
	always_comb begin
		re    = (state_q == S_RD);
		raddr = idx_q[AW-1:0];
		if (op_q == bal_pkg::OP_INSERT)
			raddr = AW'(idx_q - 1'b1);
		else if (op_q == bal_pkg::OP_REMOVE)
			raddr = AW'(idx_q + 1'b1);
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata_q;
		if (state_q == S_IDLE && req.valid && req.opcode == bal_pkg::OP_APPEND &&
			cnt_q < NW'(CAPACITY)) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = vin;
		end else if (state_q == S_EVAL && op_q == bal_pkg::OP_INSERT) begin
			we    = 1'b1;
			wdata = (idx_q <= pos_q) ? val_q : rdata_q;
		end else if (state_q == S_EVAL && op_q == bal_pkg::OP_REMOVE &&
			idx_q + 1'b1 < cnt_q) begin
			we = 1'b1;
		end else if (state_q == S_SORTB && idx_q != '0) begin
			// write the smaller at j, carry the larger forward
			we    = 1'b1;
			waddr = AW'(idx_q - 1'b1);
			wdata = gt ? hold_q : rdata_q;
		end else if (state_q == S_SORTW && !(idx_q + 1'b1 < lim_q)) begin
			we    = 1'b1;
			wdata = hold_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (req.valid) begin
				op_q    <= req.opcode;
				pos_q   <= NW'(req.position);
				val_q   <= vin;
				dout_q  <= '0;
				fpos_q  <= '0;
				found_q <= 1'b0;
				st_q    <= bal_pkg::ST_OK;
				lim_q   <= cnt_q;
				case (req.opcode)
					bal_pkg::OP_APPEND:
						if (cnt_q >= NW'(CAPACITY)) st_q <= bal_pkg::ST_FULL;
					bal_pkg::OP_INSERT: begin
						idx_q <= cnt_q;
						if (NW'(req.position) != '0 && NW'(req.position) >= cnt_q)
							st_q <= bal_pkg::ST_RANGE;
						else if (cnt_q >= NW'(CAPACITY))
							st_q <= bal_pkg::ST_FULL;
					end
					bal_pkg::OP_REMOVE, bal_pkg::OP_READ: begin
						idx_q <= (req.opcode == bal_pkg::OP_REMOVE) ?
							NW'(req.position) : NW'(req.position);
						if (NW'(req.position) >= cnt_q) st_q <= bal_pkg::ST_RANGE;
					end
					bal_pkg::OP_FINDF: begin
						idx_q <= '0;
						st_q  <= bal_pkg::ST_NOTFOUND;
					end
					bal_pkg::OP_FINDL: begin
						idx_q <= cnt_q - 1'b1;
						st_q  <= bal_pkg::ST_NOTFOUND;
					end
					default: idx_q <= '0;
				endcase
			end
			S_EVAL: begin
				case (op_q)
					bal_pkg::OP_INSERT: idx_q <= idx_q - 1'b1;
					bal_pkg::OP_REMOVE: idx_q <= idx_q + 1'b1;
					bal_pkg::OP_READ: dout_q <= 32'($signed(rdata_q));
					bal_pkg::OP_FINDF, bal_pkg::OP_FINDL: begin
						if (rdata_q == val_q) begin
							found_q <= 1'b1;
							fpos_q  <= idx_q[bal_pkg::POS_W-1:0];
							st_q    <= bal_pkg::ST_OK;
						end
						idx_q <= (op_q == bal_pkg::OP_FINDF) ? idx_q + 1'b1 : idx_q - 1'b1;
					end
					bal_pkg::OP_MAX: begin
						if (idx_q == '0 || gt) begin
							best_q <= rdata_q;
							dout_q <= 32'($signed(rdata_q));
						end
						idx_q <= idx_q + 1'b1;
					end
					default: ;
				endcase
			end
			S_SORTB: begin
				if (idx_q != '0 && !gt)
					hold_q <= hold_q;
				else
					hold_q <= rdata_q;
			end
			S_SORTW: begin
				if (idx_q + 1'b1 < lim_q)
					idx_q <= idx_q + 1'b1;
				else begin
					idx_q <= '0;
					lim_q <= lim_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// assertions
	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(CAPACITY)) else $error("count above capacity");
	ap_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("ready while result pending");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(cnt_q))
		else $error("count moved while result pending");
endmodule

FILE: test/bal_checker.sv
//------------------------------------------------------------------------------
// bal_checker
// Watches the request and result channels of the array list engine, keeps its
// own copy of the list, works out the result of every request transfer and
// compares each result transfer field by field with the oldest prediction.
//------------------------------------------------------------------------------
module bal_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  logic [bal_pkg::OP_W-1:0] req_opcode,
	input  logic [bal_pkg::POS_W-1:0] req_position,
	input  logic signed [bal_pkg::VAL_W-1:0] req_value,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  logic signed [bal_pkg::VAL_W-1:0] rsp_data_out,
	input  logic [bal_pkg::POS_W-1:0] rsp_found_position,
	input  logic rsp_found,
	input  logic [bal_pkg::STATUS_W-1:0] rsp_status,
	input  logic [bal_pkg::CNT_W-1:0] rsp_count,
	output int   fail_count,
	output int   pending,
	output int   result_total
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = bal_pkg::CAPACITY_DEF;

	typedef struct packed {
		logic signed [bal_pkg::VAL_W-1:0] data;
		logic [bal_pkg::POS_W-1:0]        fpos;
		logic                             found;
		bal_pkg::status_t                 status;
		logic [bal_pkg::CNT_W-1:0]        count;
	} list_result_t;

	logic signed [bal_pkg::VAL_W-1:0] shadow_list [CAP];
	int unsigned             shadow_count;
	list_result_t            result_queue [$];

	// apply one request to the shadow list and return its result
	function automatic list_result_t apply_request(logic [bal_pkg::OP_W-1:0] op,
		logic [bal_pkg::POS_W-1:0] pos, logic signed [bal_pkg::VAL_W-1:0] val);
		list_result_t r;
		logic signed [bal_pkg::VAL_W-1:0] t;
		r = '0;
		r.status = bal_pkg::ST_OK;
		case (op)
			bal_pkg::OP_APPEND: begin
				if (shadow_count >= CAP) r.status = bal_pkg::ST_FULL;
				else begin
					shadow_list[shadow_count] = val;
					shadow_count++;
				end
			end
			bal_pkg::OP_INSERT: begin
				if (pos != 0 && pos >= shadow_count) r.status = bal_pkg::ST_RANGE;
				else if (shadow_count >= CAP) r.status = bal_pkg::ST_FULL;
				else begin
					for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
					shadow_list[pos] = val;
					shadow_count++;
				end
			end
			bal_pkg::OP_REMOVE: begin
				if (pos >= shadow_count) r.status = bal_pkg::ST_RANGE;
				else begin
					for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
					shadow_count--;
				end
			end
			bal_pkg::OP_READ: begin
				if (pos >= shadow_count) r.status = bal_pkg::ST_RANGE;
				else r.data = shadow_list[pos];
			end
			bal_pkg::OP_FINDF: begin
				r.status = bal_pkg::ST_NOTFOUND;
				for (int i = 0; i < shadow_count; i++)
					if (shadow_list[i] == val) begin
						r.found = 1'b1;
						r.fpos = bal_pkg::POS_W'(i);
						r.status = bal_pkg::ST_OK;
						break;
					end
			end
			bal_pkg::OP_FINDL: begin
				r.status = bal_pkg::ST_NOTFOUND;
				for (int i = shadow_count; i > 0; i--)
					if (shadow_list[i-1] == val) begin
						r.found = 1'b1;
						r.fpos = bal_pkg::POS_W'(i - 1);
						r.status = bal_pkg::ST_OK;
						break;
					end
			end
			bal_pkg::OP_CLEAR: shadow_count = 0;
			bal_pkg::OP_SORT: begin
				for (int i = 0; i + 1 < shadow_count; i++)
					for (int j = 0; j + 1 < shadow_count - i; j++)
						if (shadow_list[j] > shadow_list[j+1]) begin
							t = shadow_list[j];
							shadow_list[j] = shadow_list[j+1];
							shadow_list[j+1] = t;
						end
			end
			bal_pkg::OP_MAX: begin
				if (shadow_count > 0) begin
					t = shadow_list[0];
					for (int i = 1; i < shadow_count; i++)
						if (shadow_list[i] > t) t = shadow_list[i];
					r.data = t;
				end
			end
			default: ;
		endcase
		r.count = bal_pkg::CNT_W'(shadow_count);
		return r;
	endfunction

	// predict on request transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		list_result_t exp_r;
		list_result_t act_r;
		if (!arst_n) begin
			shadow_count = 0;
			fail_count <= 0;
			result_total <= 0;
			pending <= 0;
			result_queue.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				result_total <= result_total + 1;
				act_r.data = rsp_data_out;
				act_r.fpos = rsp_found_position;
				act_r.found = rsp_found;
				act_r.status = bal_pkg::status_t'(rsp_status);
				act_r.count = rsp_count;
				if (result_queue.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, act_r);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = result_queue.pop_front();
					if (exp_r !== act_r) begin
						$display("%0t: mismatch expected data=%h fpos=%0d found=%0d st=%0d cnt=%0d",
							$time, exp_r.data, exp_r.fpos, exp_r.found, exp_r.status,
							exp_r.count);
						$display("%0t:          actual   data=%h fpos=%0d found=%0d st=%0d cnt=%0d",
							$time, act_r.data, act_r.fpos, act_r.found, act_r.status,
							act_r.count);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req_valid && req_ready)
				result_queue.push_back(apply_request(req_opcode, req_position, req_value));
			pending <= result_queue.size();
		end
	end
endmodule

FILE: test/tb.sv
//------------------------------------------------------------------------------
// tb
// Drives directed and random request streams into the array list engine with
// random idling on both channels and a long result hold-off, and reports the
// verdict from the checker's failure count and pending results.
//------------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 60_000_000;

	logic clk;
	logic arst_n;
	int   fail_count, pending, result_total;
	int   send_idle_pct, recv_idle_pct;
	bit   hold_results;
	longint cycles;
	int   req_total;

	bal_req_if req ();
	bal_rsp_if rsp ();

	bounded_array_list_engine_top u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	bal_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_opcode(req.opcode),
		.req_position(req.position), .req_value(req.value),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data_out(rsp.data_out),
		.rsp_found_position(rsp.found_position), .rsp_found(rsp.found),
		.rsp_status(rsp.status), .rsp_count(rsp.count),
		.fail_count(fail_count), .pending(pending), .result_total(result_total)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// timeout watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// result side ready, with random idling and the hold-off
	initial rsp.ready = 1'b0;
	always @(negedge clk)
		rsp.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);

	// one request transfer; valid stays up between back-to-back items
	task automatic send_request(logic [bal_pkg::OP_W-1:0] op,
		logic [bal_pkg::POS_W-1:0] pos, logic [bal_pkg::VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.position <= pos;
		req.value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		req_total++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [bal_pkg::VAL_W-1:0] pick_value(int pool);
		case ($urandom_range(3))
			0: return $urandom_range(pool);
			1: return -$urandom_range(pool);
			2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
			default: return $urandom;
		endcase
	endfunction

	// random phase: mostly building and probing a list, kept small
	task automatic random_phase(int n);
		int op_pick;
		logic [bal_pkg::OP_W-1:0] op;
		logic [bal_pkg::POS_W-1:0] pos;
		for (int k = 0; k < n; k++) begin
			op_pick = $urandom_range(99);
			if (op_pick < 30) op = bal_pkg::OP_APPEND;
			else if (op_pick < 45) op = bal_pkg::OP_INSERT;
			else if (op_pick < 55) op = bal_pkg::OP_REMOVE;
			else if (op_pick < 67) op = bal_pkg::OP_READ;
			else if (op_pick < 75) op = bal_pkg::OP_FINDF;
			else if (op_pick < 83) op = bal_pkg::OP_FINDL;
			else if (op_pick < 85) op = bal_pkg::OP_CLEAR;
			else if (op_pick < 89) op = bal_pkg::OP_SORT;
			else if (op_pick < 93) op = bal_pkg::OP_MAX;
			else if (op_pick < 96) op = bal_pkg::OP_COUNT;
			else op = bal_pkg::OP_W'($urandom_range(15));
			pos = ($urandom_range(9) == 0) ? bal_pkg::POS_W'($urandom) :
				bal_pkg::POS_W'($urandom_range(24));
			send_request(op, pos, pick_value(6));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = '0;
		req.position = '0;
		req.value = '0;
		hold_results = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		req_total = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-list faults and corner values
		send_request(bal_pkg::OP_MAX, 0, 0);
		send_request(bal_pkg::OP_READ, 0, 0);
		send_request(bal_pkg::OP_REMOVE, 0, 0);
		send_request(bal_pkg::OP_INSERT, 5, 1);
		send_request(bal_pkg::OP_INSERT, 0, 32'h7fff_ffff);
		send_request(bal_pkg::OP_APPEND, 0, 32'h8000_0000);
		send_request(bal_pkg::OP_INSERT, 0, 32'hffff_ffff);
		send_request(bal_pkg::OP_INSERT, 1, 0);
		send_request(bal_pkg::OP_FINDF, 0, 32'h8000_0000);
		send_request(bal_pkg::OP_FINDL, 0, 32'h7fff_ffff);
		send_request(bal_pkg::OP_FINDF, 0, 12345);
		send_request(bal_pkg::OP_FINDL, 0, 12345);
		send_request(bal_pkg::OP_MAX, 0, 0);
		send_request(bal_pkg::OP_SORT, 0, 0);
		send_request(bal_pkg::OP_READ, 3, 0);
		send_request(bal_pkg::OP_READ, 255, 0);
		send_request(bal_pkg::OP_REMOVE, 1, 0);
		send_request(bal_pkg::OP_COUNT, 0, 0);
		send_request(4'd15, 8'hff, 32'hffff_ffff);
		send_request(4'd10, 0, 0);
		send_request(bal_pkg::OP_CLEAR, 0, 0);
		send_request(bal_pkg::OP_SORT, 0, 0);
		send_request(bal_pkg::OP_APPEND, 0, 7);
		send_request(bal_pkg::OP_SORT, 0, 0);
		wait_drained();

		// fill to capacity, then full faults, then sort a full list once
		for (int i = 0; i < bal_pkg::CAPACITY_DEF; i++)
			send_request(bal_pkg::OP_APPEND, 0, $urandom);
		send_request(bal_pkg::OP_APPEND, 0, 1);
		send_request(bal_pkg::OP_INSERT, 0, 1);
		send_request(bal_pkg::OP_INSERT, 255, 1);
		send_request(bal_pkg::OP_REMOVE, 255, 0);
		send_request(bal_pkg::OP_INSERT, 254, 32'h5555_aaaa);
		send_request(bal_pkg::OP_MAX, 0, 0);
		send_request(bal_pkg::OP_SORT, 0, 0);
		send_request(bal_pkg::OP_READ, 255, 0);
		send_request(bal_pkg::OP_FINDL, 0, 32'h5555_aaaa);
		send_request(bal_pkg::OP_CLEAR, 0, 0);
		wait_drained();

		// long result hold-off while requests keep coming
		fork
			begin
				hold_results = 1'b1;
				repeat (400) @(negedge clk);
				hold_results = 1'b0;
			end
			for (int i = 0; i < 8; i++)
				send_request(bal_pkg::OP_APPEND, bal_pkg::POS_W'(i), $urandom);
		join
		wait_drained();

		send_idle_pct = 23;
		recv_idle_pct = 76;
		random_phase(450);
		wait_drained();
		send_idle_pct = 76;
		recv_idle_pct = 23;
		random_phase(450);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(450);
		wait_drained();
		repeat (50) @(negedge clk);

		$display("Covered %0d requests and %0d results: every opcode, faults, full list, sort.",
			req_total, result_total);
		if (fail_count == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/bal_pkg.sv
hw/rtl/bal_req_if.sv
hw/rtl/bal_rsp_if.sv
hw/rtl/bounded_array_list_engine_top.sv
test/bal_checker.sv
test/tb.sv
